// File: hw/rtl/js3_pkg.sv
// Shared constants and types for the 3x3 Jacobi solver.
`timescale 1ns / 1ps
package js3_pkg;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VAL_WIDTH      = 32;
  localparam int REG_WIDTH      = 16;
  localparam int NUM_WIDTH      = 64;
  localparam int CNT_WIDTH      = 16;
  localparam int OUT_WIDTH      = 2;

  localparam logic [REG_WIDTH-1:0] TOL_RESET = 16'd7;
  localparam logic [REG_WIDTH-1:0] CAP_RESET = 16'd1000;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MAX_ITER  = 1'b1;

  localparam logic [OUT_WIDTH-1:0] OUTCOME_CONVERGED = 2'd0;
  localparam logic [OUT_WIDTH-1:0] OUTCOME_CAP       = 2'd1;
  localparam logic [OUT_WIDTH-1:0] OUTCOME_ZERO_DIAG = 2'd2;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

// File: hw/rtl/js3_divider.sv
// Restoring signed 64 by COEF_WIDTH divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module js3_divider #(
  parameter int COEF_WIDTH = js3_pkg::COEF_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  js3_pkg::div_ctrl_t                 ctrl,
  input  logic signed [js3_pkg::NUM_WIDTH-1:0] dividend,
  input  logic signed [COEF_WIDTH-1:0]       divisor,
  output js3_pkg::div_stat_t                 stat,
  output logic signed [js3_pkg::NUM_WIDTH-1:0] quotient
);
  import js3_pkg::*;

  localparam int STEP_WIDTH = $clog2(NUM_WIDTH + 1);

  logic                     busy;
  logic                     done;
  logic [STEP_WIDTH-1:0]    step;
  logic [NUM_WIDTH-1:0]     quo;
  logic [NUM_WIDTH:0]       rem;
  logic [COEF_WIDTH-1:0]    dmag;
  logic                     neg;
  logic [NUM_WIDTH:0]       rem_shift;
  logic [NUM_WIDTH:0]       rem_diff;
  logic [NUM_WIDTH-1:0]     nmag;

  assign nmag      = dividend[NUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign rem_shift = {rem[NUM_WIDTH-1:0], quo[NUM_WIDTH-1]};
  assign rem_diff  = rem_shift - {{(NUM_WIDTH+1-COEF_WIDTH){1'b0}}, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        step <= STEP_WIDTH'(NUM_WIDTH);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      quo  <= nmag;
      rem  <= '0;
      dmag <= divisor[COEF_WIDTH-1] ? (~divisor + 1'b1) : divisor;
      neg  <= dividend[NUM_WIDTH-1] ^ divisor[COEF_WIDTH-1];
    end else if (busy) begin
      if (!rem_diff[NUM_WIDTH]) begin
        rem <= rem_diff;
        quo <= {quo[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[NUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient   = neg ? -$signed(quo) : $signed(quo);
  assign stat.busy  = busy;
  assign stat.done  = done;
endmodule

// File: hw/rtl/jacobi_solver_3x3_core.sv
// Top level of the 3x3 Jacobi solver: sequencer, shared multiplier and divider.
//
// Usage: pulse start with the twelve coefficients while busy is low; they are
// captured in that cycle and busy rises unless a diagonal is zero. Each sweep
// works the three rows in turn through one shared multiplier and one shared
// bit-serial divider. A row forms two products, then the full numerator, then
// its quotient in the divider and then the update; a zero diagonal returns its
// beat in the cycle after the start beat. The divider takes most of each row.
// When the item finishes, done is high for one cycle with x_value, y_value,
// z_value, sweep_count and outcome; the beat cannot be held off, and the
// values stay on the ports until the next item. tolerance and max_iterations
// are written through cfg_we, cfg_index and cfg_data; the user must do so only
// while busy is low, as the block itself does not enforce it. Reset is
// synchronous: it clears the sequencer and sets tolerance to 7 and
// max_iterations to 1000.
`timescale 1ns / 1ps
module jacobi_solver_3x3_core #(
  parameter int COEF_WIDTH = js3_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = js3_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [js3_pkg::REG_WIDTH-1:0]       cfg_data,
  input  logic signed [COEF_WIDTH-1:0]        row0_x_coef,
  input  logic signed [COEF_WIDTH-1:0]        row0_y_coef,
  input  logic signed [COEF_WIDTH-1:0]        row0_z_coef,
  input  logic signed [COEF_WIDTH-1:0]        row0_rhs,
  input  logic signed [COEF_WIDTH-1:0]        row1_x_coef,
  input  logic signed [COEF_WIDTH-1:0]        row1_y_coef,
  input  logic signed [COEF_WIDTH-1:0]        row1_z_coef,
  input  logic signed [COEF_WIDTH-1:0]        row1_rhs,
  input  logic signed [COEF_WIDTH-1:0]        row2_x_coef,
  input  logic signed [COEF_WIDTH-1:0]        row2_y_coef,
  input  logic signed [COEF_WIDTH-1:0]        row2_z_coef,
  input  logic signed [COEF_WIDTH-1:0]        row2_rhs,
  output logic signed [js3_pkg::VAL_WIDTH-1:0] x_value,
  output logic signed [js3_pkg::VAL_WIDTH-1:0] y_value,
  output logic signed [js3_pkg::VAL_WIDTH-1:0] z_value,
  output logic [js3_pkg::CNT_WIDTH-1:0]       sweep_count,
  output logic [js3_pkg::OUT_WIDTH-1:0]       outcome
);
  import js3_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_P = 3'd1;
  localparam logic [2:0] ST_MUL_Q = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;

  localparam int PROD_WIDTH = COEF_WIDTH + VAL_WIDTH;
  localparam logic signed [NUM_WIDTH-1:0] NUM_MAX = {1'b0, {(NUM_WIDTH-1){1'b1}}};
  localparam logic signed [NUM_WIDTH-1:0] NUM_MIN = {1'b1, {(NUM_WIDTH-2){1'b0}}, 1'b1};
  localparam logic signed [NUM_WIDTH-1:0] VMAX =
    NUM_WIDTH'({1'b0, {(VAL_WIDTH-1){1'b1}}});
  localparam logic signed [NUM_WIDTH-1:0] VMIN = -VMAX - 1;

  logic [REG_WIDTH-1:0] tolerance;
  logic [REG_WIDTH-1:0] max_iterations;

  logic [2:0] state;
  logic [1:0] row;
  logic signed [COEF_WIDTH-1:0] coef [12];
  logic signed [VAL_WIDTH-1:0] xv, yv, zv;     // previous iterate
  logic signed [VAL_WIDTH-1:0] nv [3];         // new iterate
  logic signed [NUM_WIDTH-1:0] num;
  logic signed [PROD_WIDTH-1:0] prod;
  logic [CNT_WIDTH-1:0] count;
  logic [REG_WIDTH-1:0] cap;
  logic all_within;

  // Per-row operand selection.
  logic signed [COEF_WIDTH-1:0] c_p, c_q, c_rhs, c_diag;
  logic signed [VAL_WIDTH-1:0]  v_u, v_v;
  logic signed [COEF_WIDTH-1:0] mul_a;
  logic signed [VAL_WIDTH-1:0]  mul_b;
  logic signed [NUM_WIDTH-1:0]  prod_ext;
  logic signed [NUM_WIDTH:0]    diff;
  logic signed [NUM_WIDTH-1:0]  sat_diff;
  logic signed [NUM_WIDTH-1:0]  quo;
  logic signed [VAL_WIDTH-1:0]  quo_sat;
  logic signed [VAL_WIDTH:0]    delta;
  logic [VAL_WIDTH:0]           delta_abs;
  logic signed [VAL_WIDTH-1:0]  old_v;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  always_comb begin
    case (row)
      2'd0: begin
        c_p = coef[1]; c_q = coef[2]; c_rhs = coef[3]; c_diag = coef[0];
        v_u = yv; v_v = zv; old_v = xv;
      end
      2'd1: begin
        c_p = coef[4]; c_q = coef[6]; c_rhs = coef[7]; c_diag = coef[5];
        v_u = xv; v_v = zv; old_v = yv;
      end
      default: begin
        c_p = coef[8]; c_q = coef[9]; c_rhs = coef[11]; c_diag = coef[10];
        v_u = xv; v_v = yv; old_v = zv;
      end
    endcase
  end

  assign mul_a    = (state == ST_MUL_P) ? c_p : c_q;
  assign mul_b    = (state == ST_MUL_P) ? v_u : v_v;
  assign prod_ext = NUM_WIDTH'(prod);
  assign diff     = {num[NUM_WIDTH-1], num} - {prod_ext[NUM_WIDTH-1], prod_ext};

  always_comb begin
    if (diff > $signed({NUM_MAX[NUM_WIDTH-1], NUM_MAX}))
      sat_diff = NUM_MAX;
    else if (diff < $signed({NUM_MIN[NUM_WIDTH-1], NUM_MIN}))
      sat_diff = NUM_MIN;
    else
      sat_diff = diff[NUM_WIDTH-1:0];
  end

  always_comb begin
    if (quo > VMAX)      quo_sat = VMAX[VAL_WIDTH-1:0];
    else if (quo < VMIN) quo_sat = VMIN[VAL_WIDTH-1:0];
    else                 quo_sat = quo[VAL_WIDTH-1:0];
  end

  assign delta     = {nv[row][VAL_WIDTH-1], nv[row]} - {old_v[VAL_WIDTH-1], old_v};
  assign delta_abs = delta[VAL_WIDTH] ? (~delta + 1'b1) : delta;

  // The division starts once the full numerator is in num, and not again
  // in the cycle that brings its quotient.
  assign div_ctrl.start = (state == ST_WAIT) && !div_stat.busy && !div_stat.done;

  js3_divider #(.COEF_WIDTH(COEF_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (num),
    .divisor  (c_diag),
    .stat     (div_stat),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOL_RESET;
      max_iterations <= CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOLERANCE) tolerance <= cfg_data;
      else                            max_iterations <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            coef[0] <= row0_x_coef; coef[1] <= row0_y_coef;
            coef[2] <= row0_z_coef; coef[3] <= row0_rhs;
            coef[4] <= row1_x_coef; coef[5] <= row1_y_coef;
            coef[6] <= row1_z_coef; coef[7] <= row1_rhs;
            coef[8] <= row2_x_coef; coef[9] <= row2_y_coef;
            coef[10] <= row2_z_coef; coef[11] <= row2_rhs;
            xv <= '0; yv <= '0; zv <= '0;
            count <= '0;
            row <= 2'd0;
            cap <= (max_iterations == '0) ? REG_WIDTH'(1) : max_iterations;
            all_within <= 1'b1;
            if (row0_x_coef == '0 || row1_y_coef == '0 || row2_z_coef == '0) begin
              x_value <= '0; y_value <= '0; z_value <= '0;
              sweep_count <= '0;
              outcome <= OUTCOME_ZERO_DIAG;
              done <= 1'b1;
            end else begin
              busy  <= 1'b1;
              state <= ST_MUL_P;
            end
          end
        end
        ST_MUL_P: begin
          prod  <= mul_a * mul_b;
          num   <= NUM_WIDTH'(c_rhs) <<< FRAC_BITS;
          state <= ST_MUL_Q;
        end
        ST_MUL_Q: begin
          num   <= sat_diff;
          prod  <= mul_a * mul_b;
          state <= ST_DIV;
        end
        ST_DIV: begin
          num   <= sat_diff;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            nv[row] <= quo_sat;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (delta_abs > (VAL_WIDTH+1)'(tolerance)) all_within <= 1'b0;
          if (row != 2'd2) begin
            row   <= row + 1'b1;
            state <= ST_MUL_P;
          end else begin
            xv <= nv[0]; yv <= nv[1]; zv <= nv[2];
            count <= count + 1'b1;
            row <= 2'd0;
            all_within <= 1'b1;
            if ((all_within && delta_abs <= (VAL_WIDTH+1)'(tolerance))
                || (count + 1'b1) >= cap) begin
              x_value <= nv[0]; y_value <= nv[1]; z_value <= nv[2];
              sweep_count <= count + 1'b1;
              outcome <= (all_within && delta_abs <= (VAL_WIDTH+1)'(tolerance))
                         ? OUTCOME_CONVERGED : OUTCOME_CAP;
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= ST_IDLE;
            end else begin
              state <= ST_MUL_P;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
